@@ src/rfpw_pkg.sv @@
// Shared types and constants for the rotated frame buffer pixel writer.
// Holds the item, result and configuration structs and all code values.
// No dependencies; every other file imports this package.
package rfpw_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int BUFFER_BYTES_DEF = 4096;
    localparam int MAX_DIM_DEF      = 512;

    // Field widths fixed by the interface.
    localparam int COORD_W    = 9;
    localparam int DIM_W      = 10;
    localparam int COLOR_W    = 8;
    localparam int ROWB_W     = 9;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int OUT_ADDR_W = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 3'd5;

    // Rotation codes.
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // Mirror control bits.
    localparam int MIRROR_H_BIT = 0;
    localparam int MIRROR_V_BIT = 1;

    // Pixel packing modes.
    localparam logic [1:0] SCALE_1BIT = 2'd0;
    localparam logic [1:0] SCALE_2BIT = 2'd1;
    localparam logic [1:0] SCALE_4BIT = 2'd2;
    localparam logic [1:0] SCALE_BAD  = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_WRITTEN = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CLEARED = 2'd2;

    // Command codes.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Leftmost field masks per packing mode.
    localparam logic [BYTE_W-1:0] MASK_1BIT = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_2BIT = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_4BIT = 8'hF0;

    // Register values after reset.
    localparam logic [DIM_W-1:0]  RST_WIDTH     = 10'd104;
    localparam logic [DIM_W-1:0]  RST_HEIGHT    = 10'd212;
    localparam logic [1:0]        RST_ROTATION  = ROT_270;
    localparam logic [1:0]        RST_MIRROR    = 2'd0;
    localparam logic [1:0]        RST_SCALE     = SCALE_1BIT;
    localparam logic [ROWB_W-1:0] RST_ROW_BYTES = 9'd13;

    typedef struct packed {
        logic               command;
        logic [COORD_W-1:0] x_pos;
        logic [COORD_W-1:0] y_pos;
        logic [COLOR_W-1:0] color;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [OUT_ADDR_W-1:0] byte_address;
        logic [BYTE_W-1:0]     byte_value;
    } result_t;

    typedef struct packed {
        logic [DIM_W-1:0]  width_pixels;
        logic [DIM_W-1:0]  height_pixels;
        logic [1:0]        rotation;
        logic [1:0]        mirror;
        logic [1:0]        scale_mode;
        logic [ROWB_W-1:0] row_bytes;
    } cfg_t;

    // Byte update for one pixel: which bits change and what they become.
    typedef struct packed {
        logic              ok;
        logic [BYTE_W-1:0] mask;
        logic [BYTE_W-1:0] bits;
    } rmw_t;

endpackage

@@ src/rfpw_ram.sv @@
// Byte-wide frame buffer memory with one write port and one registered read port.
// Depends on rfpw_pkg for the byte width.
module rfpw_ram #(
    parameter int DEPTH  = rfpw_pkg::BUFFER_BYTES_DEF,
    parameter int ADDR_W = $clog2(rfpw_pkg::BUFFER_BYTES_DEF)
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [rfpw_pkg::BYTE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [rfpw_pkg::BYTE_W-1:0] rd_data
);
    import rfpw_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/rfpw_map.sv @@
// Two-stage coordinate mapper: rotation and mirroring, then byte address and field mask.
// Depends on rfpw_pkg for the item, configuration and update structs.
module rfpw_map #(
    parameter int BUFFER_BYTES = rfpw_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_DIM      = rfpw_pkg::MAX_DIM_DEF,
    parameter int ADDR_W       = $clog2(rfpw_pkg::BUFFER_BYTES_DEF)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            launch,
    input  rfpw_pkg::item_t item,
    input  rfpw_pkg::cfg_t  cfg,
    output logic            valid,
    output logic [ADDR_W-1:0] addr,
    output rfpw_pkg::rmw_t  rmw
);
    import rfpw_pkg::*;

    localparam int PROD_W = DIM_W + ROWB_W;
    localparam int SUM_W  = PROD_W + 1;

    logic [DIM_W-1:0]   wm;
    logic [DIM_W-1:0]   hm;
    logic [DIM_W-1:0]   lw;
    logic [DIM_W-1:0]   lh;
    logic [DIM_W-1:0]   xe;
    logic [DIM_W-1:0]   ye;
    logic [DIM_W-1:0]   rx;
    logic [DIM_W-1:0]   ry;
    logic [DIM_W-1:0]   mx_next;
    logic [DIM_W-1:0]   my_next;
    logic               ok1_next;

    logic               s1_valid_reg;
    logic               s1_ok_reg;
    logic [DIM_W-1:0]   s1_mx_reg;
    logic [DIM_W-1:0]   s1_my_reg;
    logic [COLOR_W-1:0] s1_color_reg;

    logic [DIM_W-1:0]   byte_col;
    logic [PROD_W-1:0]  row_base;
    logic [SUM_W-1:0]   sum;
    logic [2:0]         shift;
    rmw_t               rmw_next;

    logic               s2_valid_reg;
    logic [ADDR_W-1:0]  addr_reg;
    rmw_t               rmw_reg;

    // Memory dimensions saturate at the largest supported size.
    assign wm = (32'(cfg.width_pixels) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg.width_pixels;
    assign hm = (32'(cfg.height_pixels) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg.height_pixels;

    // Quarter turns swap the logical width and height.
    assign lw = cfg.rotation[0] ? hm : wm;
    assign lh = cfg.rotation[0] ? wm : hm;
    assign xe = DIM_W'(item.x_pos);
    assign ye = DIM_W'(item.y_pos);
    assign ok1_next = (xe < lw) && (ye < lh) && (cfg.scale_mode != SCALE_BAD);

    // Rotation into memory coordinates. In range, none of the subtractions wrap.
    always_comb
    begin
        unique case (cfg.rotation)
            ROT_0:
            begin
                rx = xe;
                ry = ye;
            end
            ROT_90:
            begin
                rx = wm - ye - 1'b1;
                ry = xe;
            end
            ROT_180:
            begin
                rx = wm - xe - 1'b1;
                ry = hm - ye - 1'b1;
            end
            default:
            begin
                rx = ye;
                ry = hm - xe - 1'b1;
            end
        endcase
    end

    // Mirroring is applied after the rotation.
    assign mx_next = cfg.mirror[MIRROR_H_BIT] ? (wm - rx - 1'b1) : rx;
    assign my_next = cfg.mirror[MIRROR_V_BIT] ? (hm - ry - 1'b1) : ry;

    // First stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= launch;
        end
    end

    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            s1_ok_reg    <= ok1_next;
            s1_mx_reg    <= mx_next;
            s1_my_reg    <= my_next;
            s1_color_reg <= item.color;
        end
    end

    // Byte column depends on how many pixels share one byte.
    always_comb
    begin
        case (cfg.scale_mode)
            SCALE_1BIT: byte_col = s1_mx_reg >> 3;
            SCALE_2BIT: byte_col = s1_mx_reg >> 2;
            default:    byte_col = s1_mx_reg >> 1;
        endcase
    end

    // Row index times stride plus column gives the byte address.
    assign row_base = s1_my_reg * cfg.row_bytes;
    assign sum      = SUM_W'(row_base) + SUM_W'(byte_col);

    // Field mask and new bits, leftmost pixel in the most significant bits.
    always_comb
    begin
        rmw_next.ok = s1_ok_reg && (32'(sum) < BUFFER_BYTES);
        shift       = 3'd0;
        case (cfg.scale_mode)
            SCALE_1BIT:
            begin
                shift         = s1_mx_reg[2:0];
                rmw_next.mask = MASK_1BIT >> shift;
                rmw_next.bits = (s1_color_reg != '0) ? rmw_next.mask : '0;
            end
            SCALE_2BIT:
            begin
                shift         = {s1_mx_reg[1:0], 1'b0};
                rmw_next.mask = MASK_2BIT >> shift;
                rmw_next.bits = {s1_color_reg[1:0], 6'b0} >> shift;
            end
            SCALE_4BIT:
            begin
                shift         = {s1_mx_reg[0], 2'b0};
                rmw_next.mask = MASK_4BIT >> shift;
                rmw_next.bits = {s1_color_reg[3:0], 4'b0} >> shift;
            end
            default:
            begin
                rmw_next.mask = '0;
                rmw_next.bits = '0;
            end
        endcase
    end

    // Second stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            addr_reg <= sum[ADDR_W-1:0];
            rmw_reg  <= rmw_next;
        end
    end

    assign valid = s2_valid_reg;
    assign addr  = addr_reg;
    assign rmw   = rmw_reg;

endmodule

@@ src/rotated_framebuffer_pixel_writer_core.sv @@
// Rotated frame buffer pixel writer, top level: configuration, control and memory.
// Depends on rfpw_pkg, rfpw_map and rfpw_ram.
//
// Usage: an item is transferred when start is high and busy is low. A set-pixel
// item maps (x_pos, y_pos) through rotation and mirroring, then reads, modifies
// and writes one byte of the frame buffer. A clear item fills row_bytes times
// height_pixels bytes, capped at the buffer size, with the replicated color.
// Each item gives one result, shown on result for the single cycle in which done
// is high; the receiver cannot stall it. Configuration is written through
// cfg_write, cfg_index and cfg_data while busy is low.
// Sequence: a written pixel passes the two mapping stages, the memory read and the
// write-back cycle that registers the result, and the next item can be transferred
// at the edge that ends the done cycle, so pixels do not overlap. A clear writes
// one byte per cycle through the single write port, driven by the clear walker; an
// empty clear or one in the undefined packing mode writes nothing.
// Reset restores the register defaults and idles the control; the buffer
// contents are undefined until cleared.
module rotated_framebuffer_pixel_writer_core #(
    parameter int BUFFER_BYTES = rfpw_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_DIM      = rfpw_pkg::MAX_DIM_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rfpw_pkg::item_t               item,
    output logic                          done,
    output rfpw_pkg::result_t             result,
    input  logic                          cfg_write,
    input  logic [rfpw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfpw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rfpw_pkg::*;

    localparam int ADDR_W = $clog2(BUFFER_BYTES);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int PROD_W = DIM_W + ROWB_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAP   = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_CLEAR = 2'd3;

    cfg_t              cfg_reg;
    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [ADDR_W-1:0] clear_index_reg;
    logic [ADDR_W-1:0] clear_index_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [BYTE_W-1:0] fill_reg;
    logic [BYTE_W-1:0] fill_next;
    logic              done_reg;
    logic              done_next;
    result_t           result_reg;
    result_t           result_next;

    logic              accept;
    logic [PROD_W-1:0] clear_prod;
    logic              map_valid;
    logic [ADDR_W-1:0] map_addr;
    rmw_t              map_rmw;

    logic              rd_en;
    logic [BYTE_W-1:0] rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [CNT_W-1:0]  clear_pos;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width_pixels  <= RST_WIDTH;
            cfg_reg.height_pixels <= RST_HEIGHT;
            cfg_reg.rotation      <= RST_ROTATION;
            cfg_reg.mirror        <= RST_MIRROR;
            cfg_reg.scale_mode    <= RST_SCALE;
            cfg_reg.row_bytes     <= RST_ROW_BYTES;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WIDTH:     cfg_reg.width_pixels  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT:    cfg_reg.height_pixels <= cfg_data[DIM_W-1:0];
                REG_ROTATION:  cfg_reg.rotation      <= cfg_data[1:0];
                REG_MIRROR:    cfg_reg.mirror        <= cfg_data[1:0];
                REG_SCALE:     cfg_reg.scale_mode    <= cfg_data[1:0];
                REG_ROW_BYTES: cfg_reg.row_bytes     <= cfg_data[ROWB_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Coordinate mapping pipeline.
    rfpw_map #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_DIM      (MAX_DIM),
        .ADDR_W       (ADDR_W)
    ) u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .launch (accept && (item.command == CMD_PIXEL)),
        .item   (item),
        .cfg    (cfg_reg),
        .valid  (map_valid),
        .addr   (map_addr),
        .rmw    (map_rmw)
    );

    // Frame buffer storage.
    rfpw_ram #(
        .DEPTH  (BUFFER_BYTES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (map_addr),
        .rd_data (rd_data)
    );

    // Clear fill byte and byte count, captured at the transfer.
    assign clear_prod = cfg_reg.row_bytes * cfg_reg.height_pixels;

    always_comb
    begin
        case (cfg_reg.scale_mode)
            SCALE_1BIT: fill_next = item.color;
            SCALE_2BIT: fill_next = {4{item.color[1:0]}};
            SCALE_4BIT: fill_next = {2{item.color[3:0]}};
            default:    fill_next = '0;
        endcase
        count_next = (32'(clear_prod) > BUFFER_BYTES) ? CNT_W'(BUFFER_BYTES)
                                                      : CNT_W'(clear_prod);
    end

    assign clear_pos = {1'b0, clear_index_reg} + 1'b1;

    // Control sequencer: pixel read-modify-write and the clear walker.
    always_comb
    begin
        state_next       = state_reg;
        clear_index_next = clear_index_reg;
        done_next        = 1'b0;
        result_next      = result_reg;
        rd_en            = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = map_addr;
        wr_data          = (rd_data & ~map_rmw.mask) | (map_rmw.bits & map_rmw.mask);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (item.command == CMD_CLEAR) ? S_CLEAR : S_MAP;
                end
            end
            S_MAP:
            begin
                if (map_valid)
                begin
                    if (map_rmw.ok)
                    begin
                        rd_en      = 1'b1;
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        result_next = '{STATUS_IGNORED, '0, '0};
                        state_next  = S_IDLE;
                    end
                end
            end
            S_WRITE:
            begin
                wr_en       = 1'b1;
                done_next   = 1'b1;
                result_next = '{STATUS_WRITTEN, OUT_ADDR_W'(map_addr), wr_data};
                state_next  = S_IDLE;
            end
            S_CLEAR:
            begin
                wr_addr = clear_index_reg;
                wr_data = fill_reg;
                if (cfg_reg.scale_mode == SCALE_BAD)
                begin
                    done_next   = 1'b1;
                    result_next = '{STATUS_IGNORED, '0, '0};
                    state_next  = S_IDLE;
                end
                else if (count_reg == '0)
                begin
                    done_next   = 1'b1;
                    result_next = '{STATUS_CLEARED, '0, '0};
                    state_next  = S_IDLE;
                end
                else
                begin
                    wr_en = 1'b1;
                    if (clear_pos == count_reg)
                    begin
                        done_next        = 1'b1;
                        result_next      = '{STATUS_CLEARED,
                                             OUT_ADDR_W'(clear_index_reg), fill_reg};
                        clear_index_next = '0;
                        state_next       = S_IDLE;
                    end
                    else
                    begin
                        clear_index_next = clear_pos[ADDR_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            clear_index_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clear_index_reg <= clear_index_next;
            done_reg        <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            fill_reg  <= fill_next;
            count_reg <= count_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ dv/rotated_framebuffer_pixel_writer_core_test.sv @@
// Self-checking testbench for rotated_framebuffer_pixel_writer_core.
// Sends pixel and clear commands under many register settings and checks every
// result against an in-bench copy of the frame buffer. Depends on rfpw_pkg.
module rotated_framebuffer_pixel_writer_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rfpw_pkg::*;

    localparam int FB_BYTES      = BUFFER_BYTES_DEF;
    localparam int FB_AW         = $clog2(FB_BYTES);
    localparam int DIM_LIMIT     = MAX_DIM_DEF;
    // Long enough for a full clear, which runs with no transfer.
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 1260;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    item_t                 item_in   = '0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  busy;
    logic                  done;
    result_t               result_out;

    // Bench copy of the registers and of the frame buffer contents.
    cfg_t              cur_cfg;
    logic [BYTE_W-1:0] frame_copy [FB_BYTES];
    result_t           pending_writes [$];
    result_t           want_result;

    int err_count   = 0;
    int n_items     = 0;
    int n_written   = 0;
    int n_ignored   = 0;
    int n_cleared   = 0;
    int n_settings  = 0;
    int idle_cycles = 0;

    rotated_framebuffer_pixel_writer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item_in),
        .done      (done),
        .result    (result_out),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Work out the result that one command gives and update the buffer copy.
    function automatic result_t predict_write(item_t it);
        result_t           r;
        int                x, y, wm, hm, lw, lh, mx, my, addr, cnt, sh;
        logic [BYTE_W-1:0] fill, old, nv;
        r = '0;
        if (it.command == CMD_CLEAR)
        begin
            if (cur_cfg.scale_mode == SCALE_1BIT)
                fill = it.color;
            else if (cur_cfg.scale_mode == SCALE_2BIT)
                fill = {4{it.color[1:0]}};
            else if (cur_cfg.scale_mode == SCALE_4BIT)
                fill = {2{it.color[3:0]}};
            else
            begin
                r.status = STATUS_IGNORED;
                return r;
            end
            cnt = int'(cur_cfg.row_bytes) * int'(cur_cfg.height_pixels);
            if (cnt > FB_BYTES)
                cnt = FB_BYTES;
            r.status = STATUS_CLEARED;
            if (cnt == 0)
                return r;
            for (int i = 0; i < cnt; i++)
                frame_copy[FB_AW'(i)] = fill;
            r.byte_address = OUT_ADDR_W'(cnt - 1);
            r.byte_value   = fill;
            return r;
        end

        x  = int'(it.x_pos);
        y  = int'(it.y_pos);
        wm = (cur_cfg.width_pixels > DIM_LIMIT) ? DIM_LIMIT : int'(cur_cfg.width_pixels);
        hm = (cur_cfg.height_pixels > DIM_LIMIT) ? DIM_LIMIT : int'(cur_cfg.height_pixels);
        lw = cur_cfg.rotation[0] ? hm : wm;
        lh = cur_cfg.rotation[0] ? wm : hm;
        if (x >= lw || y >= lh || cur_cfg.scale_mode == SCALE_BAD)
        begin
            r.status = STATUS_IGNORED;
            return r;
        end

        // Rotation first, then mirroring, both in memory coordinates.
        case (cur_cfg.rotation)
            ROT_0:
            begin
                mx = x;
                my = y;
            end
            ROT_90:
            begin
                mx = wm - 1 - y;
                my = x;
            end
            ROT_180:
            begin
                mx = wm - 1 - x;
                my = hm - 1 - y;
            end
            default:
            begin
                mx = y;
                my = hm - 1 - x;
            end
        endcase
        if (cur_cfg.mirror[MIRROR_H_BIT])
            mx = wm - 1 - mx;
        if (cur_cfg.mirror[MIRROR_V_BIT])
            my = hm - 1 - my;

        if (cur_cfg.scale_mode == SCALE_1BIT)
            addr = (mx >> 3) + my * int'(cur_cfg.row_bytes);
        else if (cur_cfg.scale_mode == SCALE_2BIT)
            addr = (mx >> 2) + my * int'(cur_cfg.row_bytes);
        else
            addr = (mx >> 1) + my * int'(cur_cfg.row_bytes);
        if (addr >= FB_BYTES)
        begin
            r.status = STATUS_IGNORED;
            return r;
        end

        // Leftmost pixel sits in the most significant bits of the byte.
        old = frame_copy[FB_AW'(addr)];
        if (cur_cfg.scale_mode == SCALE_1BIT)
        begin
            sh = mx % 8;
            nv = (it.color != 0) ? (old | (MASK_1BIT >> sh)) : (old & ~(MASK_1BIT >> sh));
        end
        else if (cur_cfg.scale_mode == SCALE_2BIT)
        begin
            sh = (mx % 4) * 2;
            nv = (old & ~(MASK_2BIT >> sh)) | ({it.color[1:0], 6'b0} >> sh);
        end
        else
        begin
            sh = (mx % 2) * 4;
            nv = (old & ~(MASK_4BIT >> sh)) | ({it.color[3:0], 4'b0} >> sh);
        end
        frame_copy[FB_AW'(addr)] = nv;
        r.status       = STATUS_WRITTEN;
        r.byte_address = OUT_ADDR_W'(addr);
        r.byte_value   = nv;
        return r;
    endfunction

    function automatic item_t make_item(logic cmd, int x, int y, logic [COLOR_W-1:0] color);
        item_t it;
        it.command = cmd;
        it.x_pos   = COORD_W'(x);
        it.y_pos   = COORD_W'(y);
        it.color   = color;
        return it;
    endfunction

    function automatic cfg_t make_setup(int w, int h, logic [1:0] rot, logic [1:0] mir,
                                        logic [1:0] scale, int rb);
        cfg_t c;
        c.width_pixels  = DIM_W'(w);
        c.height_pixels = DIM_W'(h);
        c.rotation      = rot;
        c.mirror        = mir;
        c.scale_mode    = scale;
        c.row_bytes     = ROWB_W'(rb);
        return c;
    endfunction

    // Mostly small images with a stride that fits the width, sometimes anything.
    function automatic cfg_t random_setup();
        cfg_t c;
        int   w, h, bpp, rb_need;
        case ($urandom_range(0, 9))
            0:       w = $urandom_range(0, 1023);
            1, 2:    w = $urandom_range(65, 512);
            default: w = $urandom_range(1, 64);
        endcase
        case ($urandom_range(0, 9))
            0:       h = $urandom_range(0, 1023);
            1:       h = $urandom_range(65, 512);
            default: h = $urandom_range(1, 64);
        endcase
        c.width_pixels  = DIM_W'(w);
        c.height_pixels = DIM_W'(h);
        c.rotation      = 2'($urandom_range(0, 3));
        c.mirror        = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 11) == 0)
            c.scale_mode = SCALE_BAD;
        else
            c.scale_mode = 2'($urandom_range(0, 2));
        bpp     = 1 << c.scale_mode;
        rb_need = (((w > DIM_LIMIT) ? DIM_LIMIT : w) * bpp + 7) / 8;
        if ($urandom_range(0, 7) == 0)
            c.row_bytes = ROWB_W'($urandom_range(0, 511));
        else
            c.row_bytes = ROWB_W'(rb_need + int'($urandom_range(0, 3)));
        return c;
    endfunction

    // Mostly in-range pixels, some points anywhere, and a few clears.
    function automatic item_t random_item();
        item_t it;
        int    wm, hm, lw, lh, pick;
        wm   = (cur_cfg.width_pixels > DIM_LIMIT) ? DIM_LIMIT : int'(cur_cfg.width_pixels);
        hm   = (cur_cfg.height_pixels > DIM_LIMIT) ? DIM_LIMIT : int'(cur_cfg.height_pixels);
        lw   = cur_cfg.rotation[0] ? hm : wm;
        lh   = cur_cfg.rotation[0] ? wm : hm;
        pick = $urandom_range(0, 99);
        it.command = CMD_PIXEL;
        it.x_pos   = COORD_W'($urandom_range(0, 511));
        it.y_pos   = COORD_W'($urandom_range(0, 511));
        it.color   = COLOR_W'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
            it.color = '0;
        if (pick < 4)
            it.command = CMD_CLEAR;
        else if (pick < 84 && lw > 0 && lh > 0)
        begin
            it.x_pos = COORD_W'($urandom_range(0, lw - 1));
            it.y_pos = COORD_W'($urandom_range(0, lh - 1));
        end
        return it;
    endfunction

    // Offer one command and hold it until the block takes it; start stays high.
    task automatic send_item(input item_t it);
        result_t r;
        start   <= 1'b1;
        item_in <= it;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        r = predict_write(it);
        pending_writes.push_back(r);
        n_items++;
        if (r.status == STATUS_WRITTEN)
            n_written++;
        else if (r.status == STATUS_CLEARED)
            n_cleared++;
        else
            n_ignored++;
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Let every outstanding command finish before touching the registers.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_writes.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_WIDTH:     cur_cfg.width_pixels  = value[DIM_W-1:0];
            REG_HEIGHT:    cur_cfg.height_pixels = value[DIM_W-1:0];
            REG_ROTATION:  cur_cfg.rotation      = value[1:0];
            REG_MIRROR:    cur_cfg.mirror        = value[1:0];
            REG_SCALE:     cur_cfg.scale_mode    = value[1:0];
            REG_ROW_BYTES: cur_cfg.row_bytes     = value[ROWB_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic apply_setup(input cfg_t c);
        wait_idle();
        write_reg(REG_WIDTH, int'(c.width_pixels));
        write_reg(REG_HEIGHT, int'(c.height_pixels));
        write_reg(REG_ROTATION, int'(c.rotation));
        write_reg(REG_MIRROR, int'(c.mirror));
        write_reg(REG_SCALE, int'(c.scale_mode));
        write_reg(REG_ROW_BYTES, int'(c.row_bytes));
        n_settings++;
    endtask

    // Reset register values: clear the default image, then plot corners and
    // points just past the logical edges.
    task automatic check_reset_defaults();
        send_item(make_item(CMD_CLEAR, 0, 0, 8'h5A));
        send_item(make_item(CMD_PIXEL, 0, 0, 8'h01));
        send_item(make_item(CMD_PIXEL, 211, 103, 8'h80));
        send_item(make_item(CMD_PIXEL, 5, 7, 8'h3C));
        send_item(make_item(CMD_PIXEL, 5, 7, 8'h00));
        send_item(make_item(CMD_PIXEL, 212, 0, 8'hFF));
        send_item(make_item(CMD_PIXEL, 0, 104, 8'hFF));
    endtask

    // Fill every byte of the buffer so that later pixels always read known data.
    task automatic check_full_clear();
        apply_setup(make_setup(512, 16, ROT_0, 2'd0, SCALE_2BIT, 256));
        send_item(make_item(CMD_CLEAR, 0, 0, 8'hF6));
    endtask

    // Each rotation with two mirror settings, across the packing modes.
    task automatic check_rotation_mirror();
        logic [1:0] mir;
        for (int r = 0; r < 4; r++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                mir = 2'(k ? (r ^ 3) : r);
                apply_setup(make_setup(20, 12, 2'(r), mir, 2'((r + k) % 3), 10));
                send_item(make_item(CMD_PIXEL, 3, 2,
                                    COLOR_W'(8'hA0 | (r * 4 + int'(mir) + 1))));
            end
        end
    endtask

    // Undefined packing, empty clears, zero stride, addresses past the buffer
    // and sizes that saturate at the largest dimension.
    task automatic check_special_cases();
        apply_setup(make_setup(16, 16, ROT_0, 2'd0, SCALE_BAD, 4));
        send_item(make_item(CMD_PIXEL, 1, 1, 8'hFF));
        send_item(make_item(CMD_CLEAR, 0, 0, 8'hFF));
        apply_setup(make_setup(16, 0, ROT_0, 2'd0, SCALE_1BIT, 4));
        send_item(make_item(CMD_CLEAR, 0, 0, 8'h33));
        apply_setup(make_setup(16, 8, ROT_90, 2'd0, SCALE_1BIT, 0));
        send_item(make_item(CMD_CLEAR, 0, 0, 8'h33));
        send_item(make_item(CMD_PIXEL, 0, 0, 8'h01));
        apply_setup(make_setup(512, 512, ROT_0, 2'd0, SCALE_4BIT, 256));
        send_item(make_item(CMD_PIXEL, 511, 511, 8'h0F));
        send_item(make_item(CMD_PIXEL, 511, 15, 8'hFF));
        apply_setup(make_setup(1023, 1023, ROT_180, 2'd3, SCALE_1BIT, 1));
        send_item(make_item(CMD_PIXEL, 511, 511, 8'h01));
        send_item(make_item(CMD_PIXEL, 0, 0, 8'hFE));
    endtask

    // Random settings, each followed by a stretch of commands sent in bursts
    // with random gaps; some stretches run back to back.
    task automatic check_random_traffic();
        int stop_at, burst_len, phase_len;
        bit steady;
        stop_at = n_items + RANDOM_ITEMS;
        while (n_items < stop_at)
        begin
            apply_setup(random_setup());
            steady    = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(20, 60);
            burst_len = $urandom_range(1, 12);
            repeat (phase_len)
            begin
                send_item(random_item());
                burst_len--;
                if (!steady && burst_len == 0)
                begin
                    hold_off($urandom_range(1, 6));
                    burst_len = $urandom_range(1, 12);
                end
            end
        end
    endtask

    task automatic compare_field(input string field, input logic [11:0] want,
                                 input logic [11:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            err_count++;
        end
    endtask

    // Every result transfer is checked against the oldest pending write.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_writes.size() == 0)
            begin
                $display("%0t: unexpected result, status %0h address %0h value %0h",
                         $time, result_out.status, result_out.byte_address,
                         result_out.byte_value);
                err_count++;
            end
            else
            begin
                want_result = pending_writes.pop_front();
                compare_field("status", 12'(want_result.status), 12'(result_out.status));
                compare_field("byte_address", want_result.byte_address,
                              result_out.byte_address);
                compare_field("byte_value", 12'(want_result.byte_value),
                              12'(result_out.byte_value));
            end
        end
    end

    // Watchdog: end the run if no transfer happens for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("rotated_framebuffer_pixel_writer_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        cur_cfg = make_setup(int'(RST_WIDTH), int'(RST_HEIGHT), RST_ROTATION, RST_MIRROR,
                             RST_SCALE, int'(RST_ROW_BYTES));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_reset_defaults();
        check_full_clear();
        check_rotation_mirror();
        check_special_cases();
        check_random_traffic();
        wait_idle();

        $display("Sent %0d commands over %0d register settings:", n_items, n_settings);
        $display("%0d pixel writes, %0d ignored points, %0d clears.",
                 n_written, n_ignored, n_cleared);
        if (err_count == 0)
            $display("rotated_framebuffer_pixel_writer_core: match");
        else
            $display("rotated_framebuffer_pixel_writer_core: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
src/rfpw_pkg.sv
src/rfpw_ram.sv
src/rfpw_map.sv
src/rotated_framebuffer_pixel_writer_core.sv
dv/rotated_framebuffer_pixel_writer_core_test.sv
